@@ src/xdve_pkg.sv @@
`timescale 1ns / 1ps
// Package for the XOR delta vector encoder: constants, item types and the
// zero-count helpers. No dependencies.

package xdve_pkg;

    localparam int MAX_LENGTH = 1024;
    localparam int IDX_W      = $clog2(MAX_LENGTH);
    localparam int LEN_W      = 11;
    localparam int CNT_W      = 11;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [1:0] CMD_FIRST  = 2'd0;
    localparam logic [1:0] CMD_SECOND = 2'd1;
    localparam logic [1:0] CMD_LATER  = 2'd2;

    // leading count that no real XOR can reach, so the window is never reused
    localparam logic [5:0] LEAD_NONE = 6'd32;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] word;
    } t_in_item;

    typedef struct packed {
        logic [31:0]      raw_word;
        logic             first_control;
        logic             second_control_valid;
        logic             second_control;
        logic             new_window;
        logic [4:0]       lz_count;
        logic [4:0]       tz_count;
        logic [31:0]      payload;
        logic [5:0]       payload_bits;
        logic             last;
        logic [CNT_W-1:0] window_count;
        logic [CNT_W-1:0] control_two_count;
    } t_out_item;

    // classified item passed from the front to the back through the queue
    typedef struct packed {
        logic [31:0]      word;
        logic             raw;
        logic             later;
        logic             vstart;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_task;

    // one element's stored state
    typedef struct packed {
        logic [31:0] prev;
        logic [5:0]  lead;
        logic [4:0]  trail;
    } t_entry;

    function automatic logic [4:0] clz32(input logic [31:0] x);
        logic [31:0] v;
        logic [4:0]  n;
        v = x;
        n = '0;
        if (v[31:16] == 16'd0) begin
            n[4] = 1'b1;
            v    = {v[15:0], 16'd0};
        end
        if (v[31:24] == 8'd0) begin
            n[3] = 1'b1;
            v    = {v[23:0], 8'd0};
        end
        if (v[31:28] == 4'd0) begin
            n[2] = 1'b1;
            v    = {v[27:0], 4'd0};
        end
        if (v[31:30] == 2'd0) begin
            n[1] = 1'b1;
            v    = {v[29:0], 2'd0};
        end
        if (v[31] == 1'b0) begin
            n[0] = 1'b1;
        end
        return n;
    endfunction

    function automatic logic [4:0] ctz32(input logic [31:0] x);
        logic [31:0] r;
        for (int i = 0; i < 32; i++) begin
            r[i] = x[31-i];
        end
        return clz32(r);
    endfunction

endpackage

@@ src/xdve_in_if.sv @@
`timescale 1ns / 1ps
// Input item channel: valid/ready handshake carrying command and word.
// Depends on xdve_pkg.

interface xdve_in_if;
    logic               valid;
    logic               ready;
    xdve_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/xdve_out_if.sv @@
`timescale 1ns / 1ps
// Result item channel: valid/ready handshake carrying one encoded item.
// Depends on xdve_pkg.

interface xdve_out_if;
    logic                valid;
    logic                ready;
    xdve_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/xdve_cfg_if.sv @@
`timescale 1ns / 1ps
// Configuration write channel carrying the vector length register.
// Depends on xdve_pkg.

interface xdve_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [xdve_pkg::LEN_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/xdve_front.sv @@
`timescale 1ns / 1ps
// Front end: vector length register, element counter and item classification.
// Depends on xdve_pkg, xdve_in_if and xdve_cfg_if.

module xdve_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    xdve_in_if.sink             i_in,
    xdve_cfg_if.sink            i_cfg,
    input  logic                i_q_ready,
    output logic                o_q_valid,
    output xdve_pkg::t_task     o_q_task
);

    logic [xdve_pkg::LEN_W-1:0] r_len;
    logic [xdve_pkg::IDX_W-1:0] r_cnt;
    logic [xdve_pkg::IDX_W-1:0] n_cnt;
    logic [xdve_pkg::LEN_W-1:0] len_eff;
    logic [xdve_pkg::IDX_W:0]   cnt_inc;
    logic                       is_last;
    logic                       accept;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = i_q_ready;
    assign accept      = i_in.valid && i_q_ready;

    always_comb begin
        if (r_len == '0) begin
            len_eff = xdve_pkg::LEN_W'(1);
        end else if (r_len > xdve_pkg::LEN_W'(xdve_pkg::MAX_LENGTH)) begin
            len_eff = xdve_pkg::LEN_W'(xdve_pkg::MAX_LENGTH);
        end else begin
            len_eff = r_len;
        end
    end

    assign cnt_inc = {1'b0, r_cnt} + 1'b1;
    assign is_last = xdve_pkg::LEN_W'(cnt_inc) >= len_eff;
    assign n_cnt   = is_last ? '0 : cnt_inc[xdve_pkg::IDX_W-1:0];

    always_comb begin
        o_q_valid       = i_in.valid;
        o_q_task.word   = i_in.data.word;
        o_q_task.raw    = i_in.data.command == xdve_pkg::CMD_FIRST;
        o_q_task.later  = i_in.data.command[1];
        o_q_task.vstart = r_cnt == '0;
        o_q_task.last   = is_last;
        o_q_task.idx    = r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= xdve_pkg::LEN_W'(xdve_pkg::MAX_LENGTH);
            r_cnt <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_len <= i_cfg.data;
            end
            if (accept) begin
                r_cnt <= n_cnt;
            end
        end
    end

endmodule

@@ src/xdve_queue.sv @@
`timescale 1ns / 1ps
// Short FIFO of classified items between front and back.
// Depends on xdve_pkg.

module xdve_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  xdve_pkg::t_task     i_task,
    output logic                o_ready,
    input  logic                i_pop,
    output logic                o_valid,
    output xdve_pkg::t_task     o_task
);

    xdve_pkg::t_task             r_mem [xdve_pkg::QDEPTH];
    logic [xdve_pkg::QPTR_W-1:0] r_wr;
    logic [xdve_pkg::QPTR_W-1:0] r_rd;
    logic [xdve_pkg::QCNT_W-1:0] r_cnt;
    logic                        do_push;
    logic                        do_pop;

    assign o_ready = r_cnt != xdve_pkg::QCNT_W'(xdve_pkg::QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_task  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_task;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ src/xdve_back.sv @@
`timescale 1ns / 1ps
// Back end: element store, XOR and window decision, vector totals, output register.
// Depends on xdve_pkg and xdve_out_if.

module xdve_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  xdve_pkg::t_task     i_q_task,
    output logic                o_q_pop,
    xdve_out_if.source          o_out
);

    xdve_pkg::t_entry    r_store [xdve_pkg::MAX_LENGTH];

    logic                r_s1_valid;
    xdve_pkg::t_task     r_s1;
    xdve_pkg::t_entry    r_rd;
    logic                r_byp;
    xdve_pkg::t_entry    r_byp_data;
    logic                r_out_valid;
    xdve_pkg::t_out_item r_out;
    logic [xdve_pkg::CNT_W-1:0] r_nw_tot;
    logic [xdve_pkg::CNT_W-1:0] r_c2_tot;

    logic                s1_go;
    logic                load;
    xdve_pkg::t_entry    ent;
    xdve_pkg::t_entry    wr_ent;
    xdve_pkg::t_out_item n_out;
    logic [xdve_pkg::CNT_W-1:0] n_nw_tot;
    logic [xdve_pkg::CNT_W-1:0] n_c2_tot;
    logic [31:0]         x;
    logic [4:0]          lz;
    logic [4:0]          tz;
    logic                x_zero;
    logic                reuse;
    logic                open_win;
    logic                ctl2;

    assign s1_go   = r_s1_valid && (!r_out_valid || o_out.ready);
    assign load    = i_q_valid && (!r_s1_valid || s1_go);
    assign o_q_pop = load;

    assign ent    = r_byp ? r_byp_data : r_rd;
    assign x      = r_s1.word ^ ent.prev;
    assign x_zero = x == 32'd0;
    assign lz     = xdve_pkg::clz32(x);
    assign tz     = xdve_pkg::ctz32(x);
    assign reuse  = !r_s1.raw && r_s1.later && !x_zero
                    && ({1'b0, lz} >= ent.lead) && (tz >= ent.trail);
    assign open_win = !r_s1.raw && !x_zero && !reuse;
    assign ctl2     = !r_s1.raw && r_s1.later && (x_zero || open_win);

    always_comb begin
        wr_ent.prev = r_s1.word;
        if (r_s1.raw) begin
            wr_ent.lead  = xdve_pkg::LEAD_NONE;
            wr_ent.trail = '0;
        end else if (open_win) begin
            wr_ent.lead  = {1'b0, lz};
            wr_ent.trail = tz;
        end else begin
            wr_ent.lead  = ent.lead;
            wr_ent.trail = ent.trail;
        end
    end

    always_comb begin
        n_nw_tot = (r_s1.vstart ? '0 : r_nw_tot) + xdve_pkg::CNT_W'(open_win);
        n_c2_tot = (r_s1.vstart ? '0 : r_c2_tot) + xdve_pkg::CNT_W'(ctl2);

        n_out                      = '0;
        n_out.raw_word             = r_s1.raw ? r_s1.word : 32'd0;
        n_out.first_control        = !r_s1.raw && (x_zero || (r_s1.later && open_win));
        n_out.second_control_valid = ctl2;
        n_out.second_control       = ctl2 && open_win;
        n_out.new_window           = open_win;
        n_out.last                 = r_s1.last;
        n_out.window_count         = n_nw_tot;
        n_out.control_two_count    = n_c2_tot;
        if (open_win) begin
            n_out.lz_count       = lz;
            n_out.tz_count       = tz;
            n_out.payload        = x >> tz;
            n_out.payload_bits   = 6'd32 - {1'b0, lz} - {1'b0, tz};
        end else if (reuse) begin
            n_out.payload        = x >> ent.trail;
            n_out.payload_bits   = 6'd32 - ent.lead - {1'b0, ent.trail};
        end
    end

    // element store: written as an item leaves the stage, read as one enters
    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_store[r_s1.idx] <= wr_ent;
        end
        if (load) begin
            r_rd <= r_store[i_q_task.idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_s1       <= i_q_task;
            r_byp      <= s1_go && (r_s1.idx == i_q_task.idx);
            r_byp_data <= wr_ent;
        end
        if (s1_go) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_nw_tot    <= '0;
            r_c2_tot    <= '0;
        end else begin
            if (load) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_out_valid <= 1'b1;
                r_nw_tot    <= n_nw_tot;
                r_c2_tot    <= n_c2_tot;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

@@ src/xor_delta_vector_encoder.sv @@
`timescale 1ns / 1ps
// XOR delta vector encoder, top level.
// Depends on xdve_pkg, the channel interfaces, xdve_front, xdve_queue, xdve_back.
//
// Usage:
//   i_in  : one item per element (command, word), valid/ready handshake.
//   o_out : one encoded item per input item, same order, valid/ready.
//   i_cfg : vector length write, always ready; write only while idle.
// Throughput: one item per cycle sustained while o_out.ready is high; the element
//   store has one write and one read port, and an element written by one item and
//   read by the next in the same cycle is forwarded around the store.
// Path: with an empty queue, an item goes from input accept through the queue,
//   the store read and the compute into the output register to output valid.
// Reset: element counter and vector totals clear, vector length goes to
//   1024; the element store is not cleared, so each element must see a
//   first vector before any second or later vector.
// Stall: when o_out.ready is low the output register holds its item, the
//   compute stage stops, and the 4-entry queue fills before i_in.ready drops.

module xor_delta_vector_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    xdve_in_if.sink    i_in,
    xdve_cfg_if.sink   i_cfg,
    xdve_out_if.source o_out
);

    logic            q_in_valid;
    logic            q_in_ready;
    xdve_pkg::t_task q_in_task;
    logic            q_out_valid;
    logic            q_pop;
    xdve_pkg::t_task q_out_task;

    xdve_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_cfg     (i_cfg),
        .i_q_ready (q_in_ready),
        .o_q_valid (q_in_valid),
        .o_q_task  (q_in_task)
    );

    xdve_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_in_valid),
        .i_task  (q_in_task),
        .o_ready (q_in_ready),
        .i_pop   (q_pop),
        .o_valid (q_out_valid),
        .o_task  (q_out_task)
    );

    xdve_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_out_valid),
        .i_q_task  (q_out_task),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

@@ sim/xor_delta_vector_encoder_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for xor_delta_vector_encoder: predicts every encoded item
// from a local model of the element store and counters, checks each result item.
// Depends on xdve_pkg, the three channel interfaces and the encoder RTL.

module xor_delta_vector_encoder_test;

    localparam logic [1:0] CMD_SPARE    = 2'd3;
    localparam int         RANDOM_ITEMS = 800;
    localparam int         SHOW_LIMIT   = 10;

    logic i_clk = 1'b0;
    logic i_rst_n;

    xdve_in_if  in_ch ();
    xdve_cfg_if cfg_ch ();
    xdve_out_if out_ch ();

    xor_delta_vector_encoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // encoder state as predicted
    logic [31:0]                hist_word [xdve_pkg::MAX_LENGTH];
    logic [7:0]                 win_lead  [xdve_pkg::MAX_LENGTH];
    logic [4:0]                 win_trail [xdve_pkg::MAX_LENGTH];
    int                         elem_pos;
    int                         nw_total;
    int                         c2_total;
    logic [xdve_pkg::LEN_W-1:0] cur_length;

    // stimulus side view of each element
    bit                         primed    [xdve_pkg::MAX_LENGTH];
    logic [31:0]                gen_word  [xdve_pkg::MAX_LENGTH];
    logic [31:0]                gen_delta [xdve_pkg::MAX_LENGTH];
    int                         gen_pos;
    int                         gen_len;
    int                         gen_stage;

    xdve_pkg::t_in_item  word_fifo    [$];
    xdve_pkg::t_out_item encoded_fifo [$];

    int bad_count, item_count, result_count, setting_count;
    int raw_words, zero_deltas, window_opens, window_reuses;
    bit in_fire, no_gaps;
    int in_gap, out_hold;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int lead_zeros(input logic [31:0] x);
        int n;
        n = 0;
        while (n < 32 && !x[31-n]) n++;
        return n;
    endfunction

    function automatic int trail_zeros(input logic [31:0] x);
        int n;
        n = 0;
        while (n < 32 && !x[n]) n++;
        return n;
    endfunction

    function automatic int effective_length(input logic [xdve_pkg::LEN_W-1:0] v);
        if (v == 0) return 1;
        if (v > xdve_pkg::MAX_LENGTH) return xdve_pkg::MAX_LENGTH;
        return int'(v);
    endfunction

    function automatic xdve_pkg::t_out_item encode_item(input xdve_pkg::t_in_item it);
        int                  len, idx, lz, tz, sl, st;
        logic [31:0]         x;
        logic                later;
        xdve_pkg::t_out_item r;
        r     = '0;
        len   = effective_length(cur_length);
        if (elem_pos == 0) begin
            nw_total = 0;
            c2_total = 0;
        end
        r.last = (elem_pos + 1 >= len);
        idx    = elem_pos % xdve_pkg::MAX_LENGTH;
        later  = it.command[1];
        if (it.command == xdve_pkg::CMD_FIRST) begin
            raw_words++;
            r.raw_word     = it.word;
            hist_word[idx] = it.word;
            win_lead[idx]  = 8'hFF;
            win_trail[idx] = 5'd0;
        end else begin
            x              = it.word ^ hist_word[idx];
            hist_word[idx] = it.word;
            if (x == 32'd0) begin
                zero_deltas++;
                r.first_control = 1'b1;
                if (later) begin
                    r.second_control_valid = 1'b1;
                    c2_total++;
                end
            end else begin
                lz = lead_zeros(x);
                tz = trail_zeros(x);
                sl = win_lead[idx];
                st = win_trail[idx];
                if (later && lz >= sl && tz >= st) begin
                    window_reuses++;
                    r.payload      = x >> st;
                    r.payload_bits = 6'(32 - sl - st);
                end else begin
                    window_opens++;
                    r.new_window     = 1'b1;
                    r.lz_count       = 5'(lz);
                    r.tz_count       = 5'(tz);
                    r.payload        = x >> tz;
                    r.payload_bits   = 6'(32 - lz - tz);
                    win_lead[idx]    = 8'(lz);
                    win_trail[idx]   = 5'(tz);
                    nw_total++;
                    if (later) begin
                        r.first_control        = 1'b1;
                        r.second_control_valid = 1'b1;
                        r.second_control       = 1'b1;
                        c2_total++;
                    end
                end
            end
        end
        elem_pos            = r.last ? 0 : elem_pos + 1;
        r.window_count      = nw_total[xdve_pkg::CNT_W-1:0];
        r.control_two_count = c2_total[xdve_pkg::CNT_W-1:0];
        return r;
    endfunction

    function automatic void flag_bad(input string what, input logic [31:0] want,
                                     input logic [31:0] got);
        bad_count++;
        if (bad_count <= SHOW_LIMIT)
            $display("%0t: result %0d %s: expected %h, got %h",
                     $time, result_count, what, want, got);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) flag_bad(name, want, got);
    endfunction

    function automatic void compare_code(input xdve_pkg::t_out_item want,
                                         input xdve_pkg::t_out_item got);
        check_field("raw_word", want.raw_word, got.raw_word);
        check_field("first_control", 32'(want.first_control), 32'(got.first_control));
        check_field("second_control_valid", 32'(want.second_control_valid),
                    32'(got.second_control_valid));
        check_field("second_control", 32'(want.second_control),
                    32'(got.second_control));
        check_field("new_window", 32'(want.new_window), 32'(got.new_window));
        check_field("lz_count", 32'(want.lz_count), 32'(got.lz_count));
        check_field("tz_count", 32'(want.tz_count), 32'(got.tz_count));
        check_field("payload", want.payload, got.payload);
        check_field("payload_bits", 32'(want.payload_bits), 32'(got.payload_bits));
        check_field("last", 32'(want.last), 32'(got.last));
        check_field("window_count", 32'(want.window_count), 32'(got.window_count));
        check_field("control_two_count", 32'(want.control_two_count),
                    32'(got.control_two_count));
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void queue_item(input logic [1:0] cmd, input logic [31:0] w);
        xdve_pkg::t_in_item it;
        logic [31:0]        d;
        it.command = cmd;
        it.word    = w;
        if (cmd == xdve_pkg::CMD_FIRST) begin
            primed[gen_pos]    = 1'b1;
            gen_delta[gen_pos] = 32'd0;
        end else begin
            d = w ^ gen_word[gen_pos];
            if (d != 32'd0) gen_delta[gen_pos] = d;
        end
        gen_word[gen_pos] = w;
        gen_pos = (gen_pos + 1 >= gen_len) ? 0 : gen_pos + 1;
        word_fifo.push_back(it);
    endfunction

    // mostly well-formed vector sequences: first, second, then later vectors
    function automatic void random_item();
        logic [1:0]  cmd;
        logic [31:0] w, mask, prev;
        int          lo, hi, r;
        if (gen_pos == 0) begin
            if ($urandom_range(0, 9) == 0) gen_stage = 0;
            else if (gen_stage < 2) gen_stage++;
        end
        case (gen_stage)
            0: cmd = xdve_pkg::CMD_FIRST;
            1: cmd = xdve_pkg::CMD_SECOND;
            default: cmd = ($urandom_range(0, 15) == 0) ? CMD_SPARE : xdve_pkg::CMD_LATER;
        endcase
        if ($urandom_range(0, 9) == 0) cmd = 2'($urandom_range(0, 3));
        if (!primed[gen_pos]) cmd = xdve_pkg::CMD_FIRST;
        prev = gen_word[gen_pos];
        r    = $urandom_range(0, 99);
        if (cmd == xdve_pkg::CMD_FIRST) begin
            if (r < 12) begin
                case ($urandom_range(0, 3))
                    0: w = 32'h0000_0000;
                    1: w = 32'hFFFF_FFFF;
                    2: w = 32'h8000_0000;
                    default: w = 32'h0000_0001;
                endcase
            end else begin
                w = $urandom();
            end
        end else if (r < 25) begin
            w = prev;
        end else if (r < 60 && gen_delta[gen_pos] != 32'd0) begin
            // change only bits inside the element's current window
            lo   = trail_zeros(gen_delta[gen_pos]);
            hi   = 31 - lead_zeros(gen_delta[gen_pos]);
            mask = 32'hFFFF_FFFF >> (31 - hi + lo) << lo;
            mask = $urandom() & mask;
            if (mask == 32'd0) mask = 32'd1 << lo;
            w = prev ^ mask;
        end else if (r < 85) begin
            w = prev ^ (32'hFFFF_FFFF >> $urandom_range(0, 31) << $urandom_range(0, 31));
        end else begin
            w = $urandom();
        end
        queue_item(cmd, w);
    endfunction

    task automatic write_length(input logic [xdve_pkg::LEN_W-1:0] v);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        gen_len = effective_length(v);
        setting_count++;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (word_fifo.size() != 0 || in_ch.valid || encoded_fifo.size() != 0);
    endtask

    // input acceptance, prediction and result checking
    always @(posedge i_clk) begin
        xdve_pkg::t_out_item want;
        in_fire = i_rst_n && in_ch.valid && in_ch.ready;
        if (in_fire) begin
            encoded_fifo.push_back(encode_item(in_ch.data));
            item_count++;
        end
        if (i_rst_n && cfg_ch.valid && cfg_ch.ready) cur_length = cfg_ch.data;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            result_count++;
            if (encoded_fifo.size() == 0) begin
                flag_bad("arrived with nothing pending", 32'd0, out_ch.data.payload);
            end else begin
                want = encoded_fifo.pop_front();
                compare_code(want, out_ch.data);
            end
        end
    end

    always @(negedge i_clk) begin
        xdve_pkg::t_in_item nxt;
        if (!in_ch.valid || in_fire) begin
            if (in_gap > 0) begin
                in_gap--;
                in_ch.valid <= 1'b0;
            end else if (word_fifo.size() != 0) begin
                nxt          = word_fifo.pop_front();
                in_ch.data  <= nxt;
                in_ch.valid <= 1'b1;
                in_gap       = pick_gap();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (out_hold > 0) begin
            out_hold--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
            out_hold      = pick_gap();
        end
    end

    initial begin
        #20_000_000;
        $display("Run timed out");
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int phase, sent, n, r;
        logic [xdve_pkg::LEN_W-1:0] len;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        out_ch.ready = 1'b0;
        cur_length   = xdve_pkg::LEN_W'(xdve_pkg::MAX_LENGTH);
        gen_len      = xdve_pkg::MAX_LENGTH;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: four-element vectors through every command and window case
        write_length(xdve_pkg::LEN_W'(4));
        queue_item(xdve_pkg::CMD_FIRST,  32'h0000_0000);
        queue_item(xdve_pkg::CMD_FIRST,  32'hFFFF_FFFF);
        queue_item(xdve_pkg::CMD_FIRST,  32'h1234_5678);
        queue_item(xdve_pkg::CMD_FIRST,  32'h8000_0001);
        queue_item(xdve_pkg::CMD_SECOND, 32'h0000_0000);
        queue_item(xdve_pkg::CMD_SECOND, 32'h0000_0000);
        queue_item(xdve_pkg::CMD_SECOND, 32'h1235_5678);
        queue_item(xdve_pkg::CMD_SECOND, 32'h8000_0000);
        queue_item(xdve_pkg::CMD_LATER,  32'h0000_0000);
        queue_item(xdve_pkg::CMD_LATER,  32'h5A5A_5A5A);
        queue_item(xdve_pkg::CMD_LATER,  32'h1237_5678);
        queue_item(CMD_SPARE,            32'h0000_0000);
        queue_item(xdve_pkg::CMD_LATER,  32'hFFFF_FFFF);
        queue_item(xdve_pkg::CMD_LATER,  32'h5A5A_5A5B);
        queue_item(xdve_pkg::CMD_LATER,  32'h1235_5678);
        queue_item(xdve_pkg::CMD_LATER,  32'h0000_0000);
        queue_item(xdve_pkg::CMD_FIRST,  32'h0000_0001);
        queue_item(xdve_pkg::CMD_FIRST,  32'h8000_0000);
        queue_item(xdve_pkg::CMD_FIRST,  32'hFFFF_FFFF);
        queue_item(xdve_pkg::CMD_FIRST,  32'h0000_0000);
        queue_item(xdve_pkg::CMD_LATER,  32'h0000_0000);
        queue_item(xdve_pkg::CMD_LATER,  32'h8000_0000);
        queue_item(xdve_pkg::CMD_LATER,  32'h7FFF_FFFF);
        queue_item(CMD_SPARE,            32'h0000_0000);
        wait_idle();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            case (phase)
                0: len = xdve_pkg::LEN_W'(1);
                1: len = xdve_pkg::LEN_W'(0);
                2: len = '1;
                default: begin
                    if (r < 5) len = xdve_pkg::LEN_W'(0);
                    else if (r < 10) len = xdve_pkg::LEN_W'(1);
                    else if (r < 14) len = '1;
                    else if (r < 18)
                        len = xdve_pkg::LEN_W'($urandom_range(xdve_pkg::MAX_LENGTH + 1,
                                                              2046));
                    else if (r < 22)
                        len = xdve_pkg::LEN_W'($urandom_range(900, xdve_pkg::MAX_LENGTH));
                    else len = xdve_pkg::LEN_W'($urandom_range(2, 40));
                end
            endcase
            write_length(len);
            no_gaps = ($urandom_range(0, 3) == 0);
            n = $urandom_range(15, 70);
            repeat (n) random_item();
            sent += n;
            phase++;
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        $display("Covered %0d items under %0d length settings, %0d results checked",
                 item_count, setting_count, result_count);
        $display("Raw words %0d, zero deltas %0d, windows opened %0d, windows reused %0d",
                 raw_words, zero_deltas, window_opens, window_reuses);
        if (bad_count == 0 && encoded_fifo.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/xdve_pkg.sv
src/xdve_in_if.sv
src/xdve_out_if.sv
src/xdve_cfg_if.sv
src/xdve_front.sv
src/xdve_queue.sv
src/xdve_back.sv
src/xor_delta_vector_encoder.sv
sim/xor_delta_vector_encoder_test.sv
